/* src/ssedf_pkg.sv */
package ssedf_pkg;

	localparam int ByteW    = 8;
	localparam int CountW   = 17;
	localparam int LenW     = 16;
	localparam int CodeW    = 3;
	localparam int CfgIdxW  = 2;
	localparam int OutDataW = 16;

	localparam logic [CountW-1:0] CountMax   = CountW'(65536);
	localparam logic [CountW-1:0] MinFrame   = CountW'(5);
	localparam logic [CountW-1:0] PayloadPos = CountW'(4);
	localparam logic [CountW-1:0] PosStart   = CountW'(0);
	localparam logic [CountW-1:0] PosLenHi   = CountW'(1);
	localparam logic [CountW-1:0] PosLenLo   = CountW'(2);
	localparam logic [CountW-1:0] PosText    = CountW'(3);

	typedef enum logic [CodeW-1:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_START = 3'd2,
		ST_BAD_TEXT  = 3'd3,
		ST_BAD_END   = 3'd4,
		ST_MISMATCH  = 3'd5
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_START = 2'd0,
		CFG_TEXT  = 2'd1,
		CFG_END   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] start_m;
		logic [ByteW-1:0] text_m;
		logic [ByteW-1:0] end_m;
	} markers_t;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] payload;
		logic             eom;
		status_t          code;
	} result_t;

endpackage

/* src/ssedf_frame_check.sv */
module ssedf_frame_check
	import ssedf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [ByteW-1:0] rx_byte,
	input  logic             final_byte,
	input  markers_t         markers,
	output result_t          result
);

	logic [CountW-1:0] count_q;
	logic [LenW-1:0]   decl_len_q;
	logic              start_bad_q;
	logic              text_bad_q;

	logic [CountW-1:0] count_nx;
	logic [LenW-1:0]   decl_len_nx;
	logic              start_bad_nx;
	logic              text_bad_nx;

	always_comb begin
		count_nx     = (count_q < CountMax) ? count_q + CountW'(1) : count_q;
		decl_len_nx  = decl_len_q;
		start_bad_nx = start_bad_q;
		text_bad_nx  = text_bad_q;
		if (count_q == PosStart) begin
			start_bad_nx = (rx_byte != markers.start_m);
		end
		if (count_q == PosLenHi) begin
			decl_len_nx = {rx_byte, decl_len_q[ByteW-1:0]};
		end
		if (count_q == PosLenLo) begin
			decl_len_nx = {decl_len_q[LenW-1:ByteW], rx_byte};
		end
		if (count_q == PosText) begin
			text_bad_nx = (rx_byte != markers.text_m);
		end
	end

	always_comb begin
		result = '{valid: 1'b0, payload: '0, eom: 1'b0, code: ST_OK};
		if (final_byte) begin
			result.valid = 1'b1;
			result.eom   = 1'b1;
			if (count_nx < MinFrame) begin
				result.code = ST_SHORT;
			end else if (start_bad_nx) begin
				result.code = ST_BAD_START;
			end else if (text_bad_nx) begin
				result.code = ST_BAD_TEXT;
			end else if (rx_byte != markers.end_m) begin
				result.code = ST_BAD_END;
			end else if (count_nx != {1'b0, decl_len_nx}) begin
				result.code = ST_MISMATCH;
			end
		end else if (count_q >= PayloadPos && !start_bad_q && !text_bad_q) begin
			result.valid   = 1'b1;
			result.payload = rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			decl_len_q  <= '0;
			start_bad_q <= 1'b0;
			text_bad_q  <= 1'b0;
		end else if (step) begin
			if (final_byte) begin
				count_q     <= '0;
				decl_len_q  <= '0;
				start_bad_q <= 1'b0;
				text_bad_q  <= 1'b0;
			end else begin
				count_q     <= count_nx;
				decl_len_q  <= decl_len_nx;
				start_bad_q <= start_bad_nx;
				text_bad_q  <= text_bad_nx;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountMax)
		else $error("byte count past saturation");

	a_clear_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		step && final_byte |=> count_q == '0 && !start_bad_q && !text_bad_q)
		else $error("frame state not cleared after final beat");

	a_payload_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.eom |-> result.code == ST_OK && count_q >= PayloadPos)
		else $error("payload beat from header position");
`endif

endmodule

/* src/soh_stx_etx_deframer_checker_unit.sv */
// soh/stx/etx deframer and frame checker
// input stream: one received byte per beat on s_axis_tdata, s_axis_tlast marks
// the last byte of the buffer
// output stream: payload bytes (tlast low, status zero) from byte position 4 on,
// then one status beat with tlast high on the buffer's last byte
// status is 0 ok, 1 short, 2 bad start, 3 bad stx, 4 bad etx, 5 length mismatch
// header and end bytes give no payload beat, nor do bytes after a marker error
// cfg port writes start, text and end markers (index 0, 1, 2); the user must write
// them only while idle, the block itself does not enforce it
// throughput: one byte per cycle if the receiver keeps up; an input register and
// a result register each advance when the stage ahead is empty or being drained
// when the receiver stalls on a pending result, the result holds and at most one
// more byte is taken into the input register before s_axis_tready drops
// reset clears the pipeline, the frame state and sets markers to 1, 2, 3
module soh_stx_etx_deframer_checker_unit
	import ssedf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [ByteW-1:0]    s_axis_tdata,  // rx_byte
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,  // payload_byte[7:0], status_code[10:8], zero
	output logic                m_axis_tlast,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [ByteW-1:0]    cfg_data
);

	markers_t         markers_q;
	logic             valid_s1;
	logic [ByteW-1:0] rx_byte_s1;
	logic             final_s1;
	logic             out_valid_q;
	logic [ByteW-1:0] payload_q;
	logic             eom_q;
	status_t          code_q;
	logic             advance;
	result_t          result;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markers_q <= '{start_m: 8'd1, text_m: 8'd2, end_m: 8'd3};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START: markers_q.start_m <= cfg_data;
				CFG_TEXT:  markers_q.text_m  <= cfg_data;
				CFG_END:   markers_q.end_m   <= cfg_data;
				default:   markers_q         <= markers_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_byte_s1 <= s_axis_tdata;
			final_s1   <= s_axis_tlast;
		end
	end

	ssedf_frame_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (rx_byte_s1),
		.final_byte (final_s1),
		.markers    (markers_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			payload_q <= result.payload;
			eom_q     <= result.eom;
			code_q    <= result.code;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OutDataW - ByteW - CodeW)'(0), code_q, payload_q};
	assign m_axis_tlast  = eom_q;

endmodule

/* tb/tb_soh_stx_etx_deframer_checker_unit.sv */
module tb_soh_stx_etx_deframer_checker_unit;
	import ssedf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit   = 1500000;
	localparam int SettleCycles = 8;
	localparam int LongHold     = 300;
	localparam int ItemTarget   = 1850;
	localparam int MaxPrinted   = 100;
	localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

	typedef logic [ByteW-1:0] byte_seq_t[$];

	typedef enum int {
		FL_NONE,
		FL_START,
		FL_TEXT,
		FL_END,
		FL_LEN,
		FL_SHORT,
		FL_NOISE
	} flaw_t;

	typedef struct {
		logic [ByteW-1:0] payload;
		logic             eom;
		status_t          code;
	} beat_t;

	class deframe_scoreboard;
		logic [ByteW-1:0]  start_mk;
		logic [ByteW-1:0]  text_mk;
		logic [ByteW-1:0]  end_mk;
		logic [CountW-1:0] rx_count;
		logic [LenW-1:0]   len_field;
		logic              start_err;
		logic              text_err;
		beat_t             expected_beats[$];
		int                errors;

		function new();
			start_mk  = 8'h01;
			text_mk   = 8'h02;
			end_mk    = 8'h03;
			errors    = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			rx_count  = '0;
			len_field = '0;
			start_err = 1'b0;
			text_err  = 1'b0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
			case (idx)
				CFG_START: start_mk = val;
				CFG_TEXT:  text_mk  = val;
				CFG_END:   end_mk   = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MaxPrinted)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function void note_byte(logic [ByteW-1:0] b, logic is_final);
			logic [CountW-1:0] pos;
			status_t           code;
			beat_t             bt;
			pos = rx_count;
			if (pos == PosStart)
				start_err = (b != start_mk);
			else if (pos == PosLenHi)
				len_field[15:8] = b;
			else if (pos == PosLenLo)
				len_field[7:0] = b;
			else if (pos == PosText)
				text_err = (b != text_mk);
			if (rx_count < CountMax)
				rx_count = rx_count + 1'b1;
			if (!is_final) begin
				if (pos >= PayloadPos && !start_err && !text_err) begin
					bt.payload = b;
					bt.eom     = 1'b0;
					bt.code    = ST_OK;
					expected_beats.insert(expected_beats.size(), bt);
				end
				return;
			end
			if (rx_count < MinFrame)
				code = ST_SHORT;
			else if (start_err)
				code = ST_BAD_START;
			else if (text_err)
				code = ST_BAD_TEXT;
			else if (b != end_mk)
				code = ST_BAD_END;
			else if (rx_count != {1'b0, len_field})
				code = ST_MISMATCH;
			else
				code = ST_OK;
			bt.payload = '0;
			bt.eom     = 1'b1;
			bt.code    = code;
			expected_beats.insert(expected_beats.size(), bt);
			clear_frame();
		endfunction

		task check_beat(logic [OutDataW-1:0] data, logic eom);
			beat_t bt;
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat data=%h last=%b", data, eom));
				return;
			end
			bt = expected_beats.pop_front();
			if (data[7:0] != bt.payload)
				report_mismatch($sformatf("payload %h, expected %h", data[7:0], bt.payload));
			if (data[10:8] != bt.code)
				report_mismatch($sformatf("status %0d, expected %s", data[10:8], bt.code.name()));
			if (eom !== bt.eom)
				report_mismatch($sformatf("tlast %b, expected %b", eom, bt.eom));
			if (data[15:11] != '0)
				report_mismatch($sformatf("pad bits %b not zero", data[15:11]));
		endtask

		task flush_leftovers();
			beat_t bt;
			while (expected_beats.size() != 0) begin
				bt = expected_beats.pop_front();
				report_mismatch($sformatf("missing beat payload=%h last=%b status=%s",
					bt.payload, bt.eom, bt.code.name()));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [ByteW-1:0]    s_axis_tdata;  // rx_byte
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;  // payload_byte[7:0], status_code[10:8], zero
	logic                m_axis_tlast;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [ByteW-1:0]    cfg_data;

	deframe_scoreboard sb;
	logic              idle_on;
	int                hold_reqs;
	int                items_sent;
	int                gap_pct;
	int                cycles;

	soh_stx_etx_deframer_checker_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// receive side: checks beats and throttles m_axis_tready
	initial begin : rx_side
		int stall_left;
		int stall_pct;
		int hold_seen;
		int tick;
		m_axis_tready = 1'b0;
		stall_left = 0;
		stall_pct = 0;
		hold_seen = 0;
		tick = 0;
		wait (sb != null);
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_beat(m_axis_tdata, m_axis_tlast);
			tick++;
			if (tick % 64 == 0)
				stall_pct = idle_on ? 10 * $urandom_range(0, 4) : 0;
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				stall_left = LongHold;
			end else if (stall_left == 0 && idle_on && $urandom_range(1, 100) <= stall_pct) begin
				stall_left = $urandom_range(1, 6);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [ByteW-1:0] b, input logic is_final);
		int gap;
		if (idle_on && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_final;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_byte(b, is_final);
		items_sent++;
	endtask

	task automatic send_buffer(input byte_seq_t seq);
		foreach (seq[i])
			send_byte(seq[i], i == seq.size() - 1);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_markers(input logic [ByteW-1:0] s, t, e);
		write_reg(CFG_START, s);
		write_reg(CFG_TEXT, t);
		write_reg(CFG_END, e);
	endtask

	function automatic logic [ByteW-1:0] pick_payload();
		case ($urandom_range(0, 15))
			0: return sb.start_mk;
			1: return sb.text_mk;
			2: return sb.end_mk;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(input int plen, input flaw_t flaw);
		byte_seq_t   seq;
		logic [15:0] len;
		int          n;
		if (flaw == FL_SHORT) begin
			n = $urandom_range(1, 4);
			seq.insert(seq.size(),
				$urandom_range(0, 1) ? sb.start_mk : 8'($urandom_range(0, 255)));
			for (int i = 1; i < n; i++) begin
				if (i == 3 && $urandom_range(0, 1))
					seq.insert(seq.size(), sb.text_mk);
				else
					seq.insert(seq.size(), 8'($urandom_range(0, 255)));
			end
			send_buffer(seq);
			return;
		end
		if (flaw == FL_NOISE) begin
			n = $urandom_range(1, 40);
			for (int i = 0; i < n; i++)
				send_byte(pick_payload(), i == n - 1 || $urandom_range(0, 9) == 0);
			return;
		end
		len = 16'(plen + 5);
		if (flaw == FL_LEN)
			len = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : len + 16'(1);
		seq.insert(seq.size(), sb.start_mk);
		seq.insert(seq.size(), len[15:8]);
		seq.insert(seq.size(), len[7:0]);
		seq.insert(seq.size(), sb.text_mk);
		for (int i = 0; i < plen; i++)
			seq.insert(seq.size(), pick_payload());
		seq.insert(seq.size(), sb.end_mk);
		case (flaw)
			FL_START: seq[0] = seq[0] ^ 8'($urandom_range(1, 255));
			FL_TEXT:  seq[3] = seq[3] ^ 8'($urandom_range(1, 255));
			FL_END:   seq[seq.size()-1] = seq[seq.size()-1] ^ 8'($urandom_range(1, 255));
			default: ;
		endcase
		send_buffer(seq);
	endtask

	task automatic random_frames(input int target);
		flaw_t flaw;
		int    plen;
		while (items_sent < target) begin
			gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
			flaw = FL_NONE;
			if ($urandom_range(0, 9) >= 7)
				flaw = flaw_t'($urandom_range(FL_START, FL_NOISE));
			plen = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
			send_frame(plen, flaw);
		end
	endtask

	initial begin
		int per_phase;
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		idle_on       = 1'b1;
		hold_reqs     = 0;
		items_sent    = 0;
		gap_pct       = 25;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames with the reset markers
		send_buffer('{8'h01, 8'h00, 8'h05, 8'h02, 8'h03});
		send_buffer('{8'h01, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h03});
		send_buffer('{8'h01});
		send_buffer('{8'hFF, 8'h00, 8'h05, 8'h02, 8'h03});
		send_buffer('{8'h01, 8'h00, 8'h06, 8'h00, 8'hAA, 8'h03});
		send_buffer('{8'h01, 8'h00, 8'h05, 8'h02, 8'h00});
		drain();

		per_phase = (ItemTarget - items_sent) / 6;

		write_reg(CfgUnused, 8'hFF);
		random_frames(items_sent + per_phase);
		drain();

		set_markers(8'h00, 8'hFF, 8'h80);
		random_frames(items_sent + per_phase);
		drain();

		// long receiver hold while bytes keep coming
		set_markers(8'hFF, 8'h00, 8'h7F);
		hold_reqs <= hold_reqs + 1;
		random_frames(items_sent + per_phase);
		drain();

		set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		write_reg(CfgUnused, 8'h00);
		random_frames(items_sent + per_phase);
		drain();

		set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		random_frames(items_sent + per_phase);
		drain();

		idle_on <= 1'b0;
		set_markers(8'h01, 8'h02, 8'h03);
		random_frames(ItemTarget);
		drain();

		sb.flush_leftovers();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
